@@ rtl/fsst_pkg.sv @@
// shared constants, command and status types, state encodings
// for the finite-strain stress transform unit; no dependencies
package fsst_pkg;

  localparam int STRETCH_FRAC_BITS = 28;

  localparam int STRETCH_W = 32;
  localparam int STRESS_W  = 48;
  localparam int SLOT_W    = 4;
  localparam int COMP_W    = 3;
  localparam int DW        = 64;
  localparam int PW        = 2 * DW;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TENSOR_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_STRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 2'd2;

  localparam logic [1:0] TS_THREE = 2'd0;
  localparam logic [1:0] TS_FOUR  = 2'd1;
  localparam logic [1:0] TS_SIX   = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_STRESS  = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_STRETCH = 4'd15;

  // scratch memory map: gradient, stress, cofactors, matrix M, product W
  localparam int RAM_DEPTH = 43;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [RAM_AW-1:0] A_F    = RAM_AW'(0);
  localparam logic [RAM_AW-1:0] A_F_ZZ = RAM_AW'(8);
  localparam logic [RAM_AW-1:0] A_P    = RAM_AW'(9);
  localparam logic [RAM_AW-1:0] A_C    = RAM_AW'(16);
  localparam logic [RAM_AW-1:0] A_M    = RAM_AW'(25);
  localparam logic [RAM_AW-1:0] A_W    = RAM_AW'(34);

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_MUL,
    DP_PACK,
    DP_ADD,
    DP_SUB,
    DP_WRITE,
    DP_JLOAD,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {SAT_NONE, SAT_J, SAT_W, SAT_S} sat_tgt_e;

  typedef enum logic [1:0] {SH_NONE, SH_ONCE, SH_TWICE} shift_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_PACK,
    ST_ACC,
    ST_WRITE,
    ST_OSTART,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } ctl_state_e;

  typedef enum logic [2:0] {PH_COF, PH_DET, PH_MAT, PH_WMT, PH_OUT} phase_e;

  typedef struct packed {
    dp_op_e              op;
    logic                acc_clr;
    logic                s_init;
    logic [1:0]          col;
    sat_tgt_e            sat_tgt;
    logic [RAM_AW-1:0]   ra;
    logic [RAM_AW-1:0]   rb;
    logic                b_one;
    shift_e              shift_sel;
    logic [1:0]          pp;
    logic [RAM_AW-1:0]   waddr;
    logic                emit_zero;
    logic [COMP_W-1:0]   component;
    logic                last_out;
    logic [1:0]          tsize;
    logic                plane;
  } dp_cmd_t;

  typedef struct packed {
    logic j_zero;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/fsst_if.sv @@
// input and result channel interfaces of the stress transform unit
// depends on fsst_pkg for field widths
interface fsst_in_if;
  logic                                valid;
  logic                                ready;
  logic [fsst_pkg::SLOT_W-1:0]         slot;
  logic signed [fsst_pkg::STRETCH_W-1:0] stretch_value;
  logic signed [fsst_pkg::STRESS_W-1:0]  stress_value;
  logic                                last;

  modport source (output valid, slot, stretch_value, stress_value, last, input ready);
  modport sink   (input valid, slot, stretch_value, stress_value, last, output ready);
endinterface

interface fsst_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [fsst_pkg::COMP_W-1:0]          component;
  logic signed [fsst_pkg::STRESS_W-1:0] stress_out;
  logic                                 singular;
  logic                                 saturated;
  logic                                 last_out;

  modport source (output valid, component, stress_out, singular, saturated, last_out,
                  input ready);
  modport sink   (input valid, component, stress_out, singular, saturated, last_out,
                  output ready);
endinterface

@@ rtl/fsst_ram.sv @@
// generic scratch memory: one write port, two registered read ports
// no dependencies
module fsst_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 43,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/fsst_ctrl.sv @@
// sequencer of the stress transform: configuration registers, phase and
// index counters, datapath commands; depends on fsst_pkg
module fsst_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fsst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_last_i,
  output logic                           in_ready_o,
  input  fsst_pkg::dp_status_t           status_i,
  output fsst_pkg::dp_cmd_t              cmd_o
);
  import fsst_pkg::*;

  ctl_state_e state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] r_q, r_d, c_q, c_d, t_q, t_d, pp_q, pp_d;
  logic [COMP_W-1:0] k_q, k_d;
  logic [6:0] div_cnt_q, div_cnt_d;
  logic [1:0] tsize_q;
  logic       plane_q, dir_q;

  logic [1:0] r1, r2, c1, c2, last_t, vr, vc;
  logic [COMP_W-1:0] last_k;
  logic [RAM_AW-1:0] ra, rb, waddr;
  logic       b_one, emit_zero;
  shift_e     shift_sel;
  sat_tgt_e   sat_tgt;
  logic [1:0] col;

  function automatic logic [1:0] inc3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  // base + 3*major + minor
  function automatic logic [RAM_AW-1:0] grid(input logic [RAM_AW-1:0] base,
                                             input logic [1:0] major,
                                             input logic [1:0] minor);
    return base + RAM_AW'(major) + RAM_AW'({major, 1'b0}) + RAM_AW'(minor);
  endfunction

  function automatic logic [RAM_AW-1:0] f_addr(input logic [1:0] row,
                                               input logic [1:0] cl);
    return grid(A_F, cl, row);
  endfunction

  // symmetric stress entry: off-diagonal pairs map to xy, xz, yz
  function automatic logic [RAM_AW-1:0] p_addr(input logic [1:0] row,
                                               input logic [1:0] cl);
    logic [2:0] idx;
    if (row == cl) idx = {1'b0, row};
    else           idx = {1'b0, row} + {1'b0, cl} + 3'd2;
    return A_P + RAM_AW'(idx);
  endfunction

  function automatic logic [1:0] voigt_row(input logic [COMP_W-1:0] k);
    case (k)
      3'd1:    return 2'd1;
      3'd2:    return 2'd2;
      3'd5:    return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] voigt_col(input logic [COMP_W-1:0] k);
    case (k)
      3'd1:    return 2'd1;
      3'd2:    return 2'd2;
      3'd3:    return 2'd1;
      3'd4:    return 2'd2;
      3'd5:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= TS_SIX;
      plane_q <= 1'b0;
      dir_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TENSOR_SIZE:  tsize_q <= cfg_data_i[1:0];
        REG_PLANE_STRESS: plane_q <= cfg_data_i[0];
        REG_DIRECTION:    dir_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_COF;
      r_q       <= 2'd0;
      c_q       <= 2'd0;
      t_q       <= 2'd0;
      pp_q      <= 2'd0;
      k_q       <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      r_q       <= r_d;
      c_q       <= c_d;
      t_q       <= t_d;
      pp_q      <= pp_d;
      k_q       <= k_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // operand and destination addresses for the current term
  always_comb begin
    r1 = inc3(r_q);
    r2 = inc3(r1);
    c1 = inc3(c_q);
    c2 = inc3(c1);
    vr = voigt_row(k_q);
    vc = voigt_col(k_q);
    ra        = A_F;
    rb        = A_F;
    waddr     = A_C;
    b_one     = 1'b0;
    shift_sel = SH_NONE;
    sat_tgt   = SAT_NONE;
    col       = 2'd0;
    last_t    = 2'd0;
    case (phase_q)
      PH_COF: begin
        ra     = (t_q == 2'd0) ? f_addr(r1, c1) : f_addr(r1, c2);
        rb     = (t_q == 2'd0) ? f_addr(r2, c2) : f_addr(r2, c1);
        waddr  = grid(A_C, r_q, c_q);
        last_t = 2'd1;
      end
      PH_DET: begin
        ra        = f_addr(2'd0, t_q);
        rb        = grid(A_C, 2'd0, t_q);
        shift_sel = SH_TWICE;
        sat_tgt   = SAT_J;
        last_t    = 2'd2;
      end
      PH_MAT: begin
        ra        = dir_q ? f_addr(r_q, c_q) : grid(A_C, c_q, r_q);
        rb        = ra;
        b_one     = 1'b1;
        waddr     = grid(A_M, r_q, c_q);
        shift_sel = dir_q ? SH_NONE : SH_ONCE;
      end
      PH_WMT: begin
        ra        = p_addr(r_q, t_q);
        rb        = grid(A_M, c_q, t_q);
        waddr     = grid(A_W, r_q, c_q);
        shift_sel = SH_ONCE;
        sat_tgt   = SAT_W;
        col       = c_q;
        last_t    = 2'd2;
      end
      PH_OUT: begin
        ra        = grid(A_M, vr, t_q);
        rb        = grid(A_W, t_q, vc);
        shift_sel = SH_ONCE;
        sat_tgt   = SAT_S;
        col       = vc;
        last_t    = 2'd2;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (tsize_q)
      TS_THREE: last_k = 3'd2;
      TS_FOUR:  last_k = 3'd3;
      default:  last_k = 3'd5;
    endcase
    emit_zero = status_i.j_zero || (tsize_q == TS_FOUR && plane_q && k_q == 3'd2);

    state_d   = state_q;
    phase_d   = phase_q;
    r_d       = r_q;
    c_d       = c_q;
    t_d       = t_q;
    pp_d      = pp_q;
    k_d       = k_q;
    div_cnt_d = div_cnt_q;
    in_ready_o = 1'b0;

    cmd_o           = '0;
    cmd_o.op        = DP_NONE;
    cmd_o.ra        = ra;
    cmd_o.rb        = rb;
    cmd_o.waddr     = waddr;
    cmd_o.b_one     = b_one;
    cmd_o.shift_sel = shift_sel;
    cmd_o.sat_tgt   = sat_tgt;
    cmd_o.col       = col;
    cmd_o.pp        = pp_q;
    cmd_o.component = k_q;
    cmd_o.last_out  = (k_q == last_k);
    cmd_o.emit_zero = emit_zero;
    cmd_o.tsize     = tsize_q;
    cmd_o.plane     = plane_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_last_i) begin
          phase_d = PH_COF;
          r_d     = 2'd0;
          c_d     = 2'd0;
          t_d     = 2'd0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.acc_clr = (t_q == 2'd0);
        state_d       = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.op = DP_LOAD;
        pp_d     = 2'd0;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.op = DP_MUL;
        pp_d     = pp_q + 2'd1;
        if (pp_q == 2'd3) state_d = ST_PACK;
      end
      ST_PACK: begin
        cmd_o.op = DP_PACK;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = (phase_q == PH_COF && t_q == 2'd1) ? DP_SUB : DP_ADD;
        if (t_q == last_t) begin
          t_d     = 2'd0;
          state_d = (phase_q == PH_OUT) ? ST_DIV_INIT : ST_WRITE;
        end else begin
          t_d     = t_q + 2'd1;
          state_d = ST_READ;
        end
      end
      ST_WRITE: begin
        state_d = ST_READ;
        if (phase_q == PH_DET) begin
          cmd_o.op = DP_JLOAD;
          phase_d  = PH_MAT;
        end else begin
          cmd_o.op = DP_WRITE;
          if (c_q == 2'd2) begin
            c_d = 2'd0;
            if (r_q == 2'd2) begin
              r_d = 2'd0;
              case (phase_q)
                PH_COF: phase_d = PH_DET;
                PH_MAT: phase_d = PH_WMT;
                default: begin
                  phase_d = PH_OUT;
                  k_d     = '0;
                  state_d = ST_OSTART;
                end
              endcase
            end else begin
              r_d = r_q + 2'd1;
            end
          end else begin
            c_d = c_q + 2'd1;
          end
        end
      end
      ST_OSTART: begin
        cmd_o.s_init = 1'b1;
        state_d      = emit_zero ? ST_EMIT : ST_READ;
      end
      ST_DIV_INIT: begin
        cmd_o.op  = DP_DIV_INIT;
        div_cnt_d = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op  = DP_DIV_STEP;
        div_cnt_d = div_cnt_q + 7'd1;
        if (div_cnt_q == 7'd127) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_EMIT;
          if (k_q == last_k) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 3'd1;
            state_d = ST_OSTART;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/fsst_dpath.sv @@
// datapath of the stress transform: scratch memory, shared 64-bit
// multiply unit, saturating accumulator, bit-serial divider, result register
// depends on fsst_pkg and fsst_ram
module fsst_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fsst_pkg::dp_cmd_t                    cmd_i,
  output fsst_pkg::dp_status_t                 status_o,
  input  logic                                 in_acc_i,
  input  logic [fsst_pkg::SLOT_W-1:0]          in_slot_i,
  input  logic signed [fsst_pkg::STRETCH_W-1:0] in_stretch_i,
  input  logic signed [fsst_pkg::STRESS_W-1:0]  in_stress_i,
  input  logic                                 in_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fsst_pkg::COMP_W-1:0]          out_component_o,
  output logic signed [fsst_pkg::STRESS_W-1:0]  out_stress_o,
  output logic                                 out_singular_o,
  output logic                                 out_saturated_o,
  output logic                                 out_last_o
);
  import fsst_pkg::*;

  localparam logic [DW-1:0] MAX64 = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN64 = {1'b1, {(DW-1){1'b0}}};
  localparam logic [STRESS_W-1:0] MAX48 = {1'b0, {(STRESS_W-1){1'b1}}};
  localparam logic [STRESS_W-1:0] MIN48 = {1'b1, {(STRESS_W-1){1'b0}}};
  localparam logic [STRETCH_W-1:0] ONE_Q = STRETCH_W'(1) << STRETCH_FRAC_BITS;
  localparam logic [RAM_AW-1:0] A_P_XY = A_P + RAM_AW'(3);
  localparam logic [RAM_AW-1:0] A_P_XZ = A_P + RAM_AW'(4);
  localparam logic [RAM_AW-1:0] A_P_YZ = A_P + RAM_AW'(5);

  logic           ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [DW-1:0]  ram_wdata, rd_a, rd_b;

  logic [STRETCH_W-1:0] stretch_q;
  logic       f8_a_q, f8_b_q, zero_a_q, zero_b_q;
  logic [DW-1:0] opnd_a, opnd_b, op_b;
  logic [DW-1:0] mag_a_q, mag_b_q;
  logic       neg_q;
  logic [PW-1:0] prod_q, pp_ext, shifted;
  logic [31:0] a_part, b_part;
  logic [DW-1:0] pp_w;
  logic [DW-1:0] res_q;
  logic       rsat_q;
  logic [DW-1:0] acc_q;
  logic [DW:0]  sum;
  logic       ovf, add_sat;
  logic [DW-1:0] add_val;
  logic       jsat_q, s_q;
  logic [2:0] wsat_q;
  logic [DW-1:0] j_q;
  logic [DW-1:0] dm_q, rem_q;
  logic [PW-1:0] num_q, quo_q;
  logic       dneg_q;
  logic [DW:0]  rr;
  logic       ge;
  logic [DW:0]  pk_p, pk_q;
  logic [DW-1:0] qv;
  logic       clip;
  logic [STRESS_W-1:0] v48;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + DW'(1)) : x;
  endfunction

  // sign-magnitude to saturated two's complement: {sat, value}
  function automatic logic [DW:0] pack(input logic neg, input logic [PW-1:0] m);
    logic [DW-1:0] lim, v;
    logic          sat;
    lim = neg ? MIN64 : MAX64;
    sat = (|m[PW-1:DW]) || (m[DW-1:0] > lim);
    v   = sat ? lim : m[DW-1:0];
    return {sat, neg ? (~v + DW'(1)) : v};
  endfunction

  fsst_ram #(.WIDTH(DW), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (cmd_i.ra),
    .raddr_b_i (cmd_i.rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd_i.waddr;
    ram_wdata = acc_q;
    if (in_acc_i) begin
      ram_we    = (in_slot_i != SLOT_STRETCH);
      ram_waddr = RAM_AW'(in_slot_i);
      ram_wdata = (in_slot_i < SLOT_STRESS)
                  ? {{(DW-STRETCH_W){in_stretch_i[STRETCH_W-1]}}, in_stretch_i}
                  : {{(DW-STRESS_W){in_stress_i[STRESS_W-1]}}, in_stress_i};
    end else if (cmd_i.op == DP_WRITE) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stretch_q <= ONE_Q;
    end else if (in_acc_i && in_slot_i == SLOT_STRETCH) begin
      stretch_q <= in_stretch_i;
    end
  end

  // substitution flags travel with the registered read
  always_ff @(posedge clk_i) begin
    f8_a_q   <= cmd_i.plane && cmd_i.ra == A_F_ZZ;
    f8_b_q   <= cmd_i.plane && cmd_i.rb == A_F_ZZ;
    zero_a_q <= (cmd_i.ra == A_P_XY && cmd_i.tsize == TS_THREE) ||
                ((cmd_i.ra == A_P_XZ || cmd_i.ra == A_P_YZ) &&
                 (cmd_i.tsize == TS_THREE || cmd_i.tsize == TS_FOUR));
    zero_b_q <= (cmd_i.rb == A_P_XY && cmd_i.tsize == TS_THREE) ||
                ((cmd_i.rb == A_P_XZ || cmd_i.rb == A_P_YZ) &&
                 (cmd_i.tsize == TS_THREE || cmd_i.tsize == TS_FOUR));
  end

  always_comb begin
    opnd_a = zero_a_q ? '0 :
             f8_a_q ? {{(DW-STRETCH_W){stretch_q[STRETCH_W-1]}}, stretch_q} : rd_a;
    opnd_b = zero_b_q ? '0 :
             f8_b_q ? {{(DW-STRETCH_W){stretch_q[STRETCH_W-1]}}, stretch_q} : rd_b;
    op_b   = cmd_i.b_one ? DW'(1) : opnd_b;
  end

  // one 32x32 partial product per cycle
  always_comb begin
    a_part = cmd_i.pp[0] ? mag_a_q[DW-1:32] : mag_a_q[31:0];
    b_part = cmd_i.pp[1] ? mag_b_q[DW-1:32] : mag_b_q[31:0];
    pp_w   = a_part * b_part;
    case ({1'b0, cmd_i.pp[0]} + {1'b0, cmd_i.pp[1]})
      2'd0:    pp_ext = {64'd0, pp_w};
      2'd1:    pp_ext = {32'd0, pp_w, 32'd0};
      default: pp_ext = {pp_w, 64'd0};
    endcase
    case (cmd_i.shift_sel)
      SH_ONCE:  shifted = prod_q >> STRETCH_FRAC_BITS;
      SH_TWICE: shifted = prod_q >> (2 * STRETCH_FRAC_BITS);
      default:  shifted = prod_q;
    endcase
    pk_p = pack(neg_q, shifted);
  end

  always_comb begin
    sum     = {acc_q[DW-1], acc_q} + {res_q[DW-1], res_q};
    ovf     = sum[DW] != sum[DW-1];
    add_val = ovf ? (sum[DW] ? MIN64 : MAX64) : sum[DW-1:0];
    add_sat = ovf || rsat_q;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        mag_a_q <= mag(opnd_a);
        mag_b_q <= mag(op_b);
        neg_q   <= opnd_a[DW-1] ^ op_b[DW-1];
        prod_q  <= '0;
      end
      DP_MUL:  prod_q <= prod_q + pp_ext;
      DP_PACK: begin
        rsat_q <= pk_p[DW];
        res_q  <= pk_p[DW-1:0];
      end
      DP_JLOAD: j_q <= acc_q;
      default: ;
    endcase
    if (cmd_i.acc_clr)             acc_q <= '0;
    else if (cmd_i.op == DP_ADD)   acc_q <= add_val;
    else if (cmd_i.op == DP_SUB)   acc_q <= acc_q - res_q;
  end

  // overflow flags: J and W flags cleared when a run starts, output flag loaded per component
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jsat_q <= 1'b0;
      wsat_q <= '0;
      s_q    <= 1'b0;
    end else if (in_acc_i && in_last_i) begin
      jsat_q <= 1'b0;
      wsat_q <= '0;
    end else if (cmd_i.s_init) begin
      s_q <= jsat_q || wsat_q[cmd_i.col];
    end else if (cmd_i.op == DP_ADD && add_sat) begin
      case (cmd_i.sat_tgt)
        SAT_J:   jsat_q <= 1'b1;
        SAT_W:   wsat_q[cmd_i.col] <= 1'b1;
        SAT_S:   s_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rr = {rem_q, num_q[PW-1]};
    ge = rr >= {1'b0, dm_q};
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_DIV_INIT: begin
        dm_q   <= mag(j_q);
        num_q  <= {{DW{1'b0}}, mag(acc_q)} << STRETCH_FRAC_BITS;
        quo_q  <= '0;
        rem_q  <= '0;
        dneg_q <= acc_q[DW-1] ^ j_q[DW-1];
      end
      DP_DIV_STEP: begin
        rem_q <= ge ? DW'(rr - {1'b0, dm_q}) : rr[DW-1:0];
        quo_q <= {quo_q[PW-2:0], ge};
        num_q <= {num_q[PW-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  always_comb begin
    pk_q = pack(dneg_q, quo_q);
    qv   = pk_q[DW-1:0];
    clip = !((&qv[DW-1:STRESS_W-1]) || !(|qv[DW-1:STRESS_W-1]));
    v48  = clip ? (qv[DW-1] ? MIN48 : MAX48) : qv[STRESS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.op == DP_EMIT) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_EMIT) begin
      out_component_o <= cmd_i.component;
      out_last_o      <= cmd_i.last_out;
      out_singular_o  <= (j_q == '0);
      out_stress_o    <= cmd_i.emit_zero ? '0 : v48;
      out_saturated_o <= !cmd_i.emit_zero && (s_q || pk_q[DW] || clip);
    end
  end

  assign status_o.j_zero   = (j_q == '0);
  assign status_o.out_free = !out_valid_o || out_ready_i;

endmodule

@@ rtl/finite_strain_stress_transform_unit.sv @@
// top level of the finite-strain stress transform unit
// depends on fsst_pkg, fsst_if, fsst_ctrl, fsst_dpath (and fsst_ram)
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      slot, stretch_value, stress_value, last
//   out_ch    out  valid/ready      component, stress_out, singular, saturated, last_out
//   cfg       in   cfg_we_i         cfg_index_i, cfg_data_i
//
// an item without last is stored; a last item starts a run through the
// cofactors, determinant, matrix and W product, each term on the shared
// four-pass 64-bit multiplier, and then computes each component with the
// 128-step bit-serial divider
// input is refused from the start of a run until the last result is loaded
// into the output register; a stalled output holds the sequencer in place
// reset is asynchronous, active low; stores read undefined until written
module finite_strain_stress_transform_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fsst_in_if.sink                        in_ch,
  fsst_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [fsst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fsst_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fsst_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready, in_acc;

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  fsst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_ch.valid),
    .in_last_i   (in_ch.last),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fsst_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_acc_i        (in_acc),
    .in_slot_i       (in_ch.slot),
    .in_stretch_i    (in_ch.stretch_value),
    .in_stress_i     (in_ch.stress_value),
    .in_last_i       (in_ch.last),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_component_o (out_ch.component),
    .out_stress_o    (out_ch.stress_out),
    .out_singular_o  (out_ch.singular),
    .out_saturated_o (out_ch.saturated),
    .out_last_o      (out_ch.last_out)
  );

endmodule

@@ test/finite_strain_stress_transform_unit_tb.sv @@
// testbench for the finite-strain stress transform unit: directed table, then
// random load sequences checked against a built-in fixed-point predictor
// depends on fsst_pkg, fsst_if and the unit's rtl
module finite_strain_stress_transform_unit_tb;
  import fsst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIM48     = 64'sd140737488355327;
  localparam longint ONE_Q28   = 64'sd1 << STRETCH_FRAC_BITS;
  localparam int     WD_LIMIT  = 20000;
  localparam int     LONG_HOLD = 3000;
  localparam int     SETTLE    = 20;

  typedef enum logic {CHK_MODEL, CHK_SINGULAR} chk_e;

  typedef struct packed {
    logic [COMP_W-1:0]   component;
    logic [STRESS_W-1:0] value;
    logic                singular;
    logic                saturated;
    logic                last_out;
  } stress_res_t;

  typedef struct {
    logic [SLOT_W-1:0]    slot;
    logic [STRETCH_W-1:0] sv;
    logic [STRESS_W-1:0]  tv;
    logic                 last;
    chk_e                 chk;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  fsst_in_if  in_ch();
  fsst_out_if out_ch();

  finite_strain_stress_transform_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint grad_q[9];
  longint stress_q[6];
  longint out_plane_stretch;
  logic [1:0] size_code;
  logic plane_mode;
  logic push_fwd;
  stress_res_t run_res[6];

  stress_res_t expected_stress[$];
  stim_row_t   stim_table[$];
  int errors = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int segment = -1;

  function automatic logic [63:0] magnitude(longint x);
    return x < 0 ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  function automatic longint clamp_signed(bit neg, logic [127:0] m, inout bit sat);
    logic [63:0] lim, v;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    v = m[63:0];
    if (m[127:64] != 0 || v > lim) begin
      sat = 1'b1;
      v = lim;
    end
    return neg ? longint'(64'd0 - v) : longint'(v);
  endfunction

  function automatic longint mul_shift(longint a, longint b, int s, inout bit sat);
    logic [127:0] p;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    return clamp_signed((a < 0) != (b < 0), p >> s, sat);
  endfunction

  function automatic longint div_shift(longint n, int s, longint d, inout bit sat);
    logic [127:0] num;
    num = {64'd0, magnitude(n)} << s;
    return clamp_signed((n < 0) != (d < 0), num / {64'd0, magnitude(d)}, sat);
  endfunction

  function automatic longint sat_add(longint a, longint b, inout bit sat);
    if (b > 0 && a > 64'sh7fff_ffff_ffff_ffff - b) begin
      sat = 1'b1;
      return 64'sh7fff_ffff_ffff_ffff;
    end
    if (b < 0 && a < 64'sh8000_0000_0000_0000 - b) begin
      sat = 1'b1;
      return 64'sh8000_0000_0000_0000;
    end
    return a + b;
  endfunction

  // stores one element; on last fills run_res and returns the component count
  function automatic int transform_stress(logic [SLOT_W-1:0] slot,
                                          logic [STRETCH_W-1:0] sv,
                                          logic [STRESS_W-1:0] tv, logic last);
    longint f[9], cof[3][3], m[3][3], p[3][3], w[3][3];
    longint jdet, acc, t, v, pr;
    bit jsat, dummy, sing, s;
    bit wsat[3];
    int n, r1, r2, c1, c2, a, b;
    jdet = 0;
    jsat = 0;
    dummy = 0;
    wsat[0] = 0; wsat[1] = 0; wsat[2] = 0;
    if (slot < SLOT_STRESS) grad_q[slot] = longint'($signed(sv));
    else if (slot < SLOT_STRETCH) stress_q[3'(slot - SLOT_STRESS)] = longint'($signed(tv));
    else out_plane_stretch = longint'($signed(sv));
    if (!last) return 0;
    n = (size_code == TS_THREE) ? 3 : (size_code == TS_FOUR) ? 4 : 6;
    for (int k = 0; k < 9; k++) f[k] = grad_q[k];
    if (plane_mode) f[8] = out_plane_stretch;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        r1 = (r + 1) % 3; r2 = (r + 2) % 3;
        c1 = (c + 1) % 3; c2 = (c + 2) % 3;
        cof[r][c] = f[r1 + 3 * c1] * f[r2 + 3 * c2] - f[r1 + 3 * c2] * f[r2 + 3 * c1];
      end
    for (int c = 0; c < 3; c++) begin
      pr = mul_shift(f[3 * c], cof[0][c], 2 * STRETCH_FRAC_BITS, jsat);
      jdet = sat_add(jdet, pr, jsat);
    end
    sing = (jdet == 0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = push_fwd ? f[r + 3 * c] : mul_shift(cof[c][r], 1, STRETCH_FRAC_BITS, dummy);
    p[0][0] = stress_q[0];
    p[1][1] = stress_q[1];
    p[2][2] = stress_q[2];
    p[0][1] = (n >= 4) ? stress_q[3] : 0;
    p[0][2] = (n == 6) ? stress_q[4] : 0;
    p[1][2] = (n == 6) ? stress_q[5] : 0;
    p[1][0] = p[0][1]; p[2][0] = p[0][2]; p[2][1] = p[1][2];
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          pr = mul_shift(p[r][j], m[k][j], STRETCH_FRAC_BITS, wsat[k]);
          acc = sat_add(acc, pr, wsat[k]);
        end
        w[r][k] = acc;
      end
    for (int k = 0; k < n; k++) begin
      v = 0;
      s = 0;
      // forced-zero zz under plane stress with four components
      if (!sing && !(n == 4 && plane_mode && k == 2)) begin
        a = (k == 0 || k == 3 || k == 4) ? 0 : (k == 1 || k == 5) ? 1 : 2;
        b = (k < 3) ? k : (k == 3) ? 1 : 2;
        t = 0;
        s = jsat || wsat[b];
        for (int j = 0; j < 3; j++) begin
          pr = mul_shift(m[a][j], w[j][b], STRETCH_FRAC_BITS, s);
          t = sat_add(t, pr, s);
        end
        v = div_shift(t, STRETCH_FRAC_BITS, jdet, s);
        if (v > LIM48) begin v = LIM48; s = 1; end
        if (v < -LIM48 - 1) begin v = -LIM48 - 1; s = 1; end
      end
      run_res[k] = '{component: COMP_W'(k), value: v[STRESS_W-1:0], singular: sing,
                     saturated: s, last_out: (k + 1 == n)};
    end
    return n;
  endfunction

  task automatic add_row(logic [SLOT_W-1:0] slot, logic [STRETCH_W-1:0] sv,
                         logic [STRESS_W-1:0] tv, logic last, chk_e chk);
    stim_table.push_back('{slot: slot, sv: sv, tv: tv, last: last, chk: chk});
  endtask

  task automatic send_item(stim_row_t row);
    int n;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.slot <= row.slot;
    in_ch.stretch_value <= row.sv;
    in_ch.stress_value <= row.tv;
    in_ch.last <= row.last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n = transform_stress(row.slot, row.sv, row.tv, row.last);
    for (int k = 0; k < n; k++)
      if (row.chk == CHK_SINGULAR)
        expected_stress.push_back('{component: COMP_W'(k), value: '0, singular: 1'b1,
                                    saturated: 1'b0, last_out: (k + 1 == n)});
      else
        expected_stress.push_back(run_res[k]);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TENSOR_SIZE) size_code = data;
    else if (idx == REG_PLANE_STRESS) plane_mode = data[0];
    else if (idx == REG_DIRECTION) push_fwd = data[0];
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_stress.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [STRETCH_W-1:0] pick_stretch(logic [SLOT_W-1:0] slot);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
      default: begin
        // near-identity gradient keeps the determinant well away from zero
        if (slot == 0 || slot == 4 || slot == 8 || slot == SLOT_STRETCH)
          return 32'(ONE_Q28) + 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      end
    endcase
  endfunction

  function automatic logic [STRESS_W-1:0] pick_stress();
    case ($urandom_range(0, 4))
      0: return 48'({$urandom, $urandom});
      1: return $urandom_range(0, 1) ? 48'h7fff_ffff_ffff : 48'h8000_0000_0000;
      default: return 48'($signed({$urandom, $urandom}) >>> $urandom_range(8, 40));
    endcase
  endfunction

  function automatic stim_row_t random_row(logic [SLOT_W-1:0] slot, logic last);
    stim_row_t row;
    row.slot = slot;
    row.sv = pick_stretch(slot);
    row.tv = pick_stress();
    row.last = last;
    row.chk = CHK_MODEL;
    return row;
  endfunction

  // result side: checks every transfer, stalls at random, one long hold-off
  int hold_cnt = 0;
  bit hold_done = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_stress.size() == 0) begin
        $display("%0t unexpected result: comp %0d val %h", $realtime, out_ch.component,
                 out_ch.stress_out);
        errors++;
      end else begin
        stress_res_t got, want;
        got = '{out_ch.component, out_ch.stress_out, out_ch.singular, out_ch.saturated,
                out_ch.last_out};
        want = expected_stress.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected comp %0d val %h sing %b sat %b last %b",
                   $realtime, want.component, want.value, want.singular, want.saturated,
                   want.last_out);
          $display("%0t            actual comp %0d val %h sing %b sat %b last %b",
                   $realtime, got.component, got.value, got.singular, got.saturated,
                   got.last_out);
          errors++;
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (segment == 4 && !hold_done) begin
      hold_done = 1;
      hold_cnt = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WD_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int sent;
    int nload;
    in_ch.valid = 1'b0;
    in_ch.slot = '0;
    in_ch.stretch_value = '0;
    in_ch.stress_value = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < 9; k++) grad_q[k] = 0;
    for (int k = 0; k < 6; k++) stress_q[k] = 0;
    out_plane_stretch = ONE_Q28;
    size_code = TS_SIX;
    plane_mode = 1'b0;
    push_fwd = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity gradient, stress extremes, then degenerate and extreme gradients
    for (int k = 0; k < 9; k++)
      add_row(SLOT_W'(k), (k % 4 == 0) ? 32'(ONE_Q28) : 32'h0, 48'({$urandom, $urandom}),
              1'b0, CHK_MODEL);
    add_row(SLOT_STRESS + 4'd0, $urandom, 48'h7fff_ffff_ffff, 1'b0, CHK_MODEL);
    add_row(SLOT_STRESS + 4'd1, $urandom, 48'h8000_0000_0000, 1'b0, CHK_MODEL);
    add_row(SLOT_STRESS + 4'd2, $urandom, 48'h0000_0001_0000, 1'b0, CHK_MODEL);
    add_row(SLOT_STRESS + 4'd3, $urandom, 48'hffff_ffff_0000, 1'b0, CHK_MODEL);
    add_row(SLOT_STRESS + 4'd4, $urandom, 48'h0000_0000_0001, 1'b0, CHK_MODEL);
    add_row(SLOT_STRESS + 4'd5, $urandom, 48'h0000_0010_0000, 1'b1, CHK_MODEL);
    add_row(SLOT_STRETCH, 32'h8000_0000, 48'h0, 1'b0, CHK_MODEL);
    add_row(4'd0, 32'h0, 48'hffff_ffff_ffff, 1'b1, CHK_SINGULAR);
    add_row(4'd0, 32'h7fff_ffff, 48'h0, 1'b1, CHK_MODEL);
    add_row(4'd4, 32'h8000_0000, 48'h0, 1'b1, CHK_MODEL);
    add_row(4'd8, 32'hffff_ffff, 48'h0, 1'b1, CHK_MODEL);
    add_row(SLOT_STRETCH, 32'h7fff_ffff, 48'h0, 1'b1, CHK_MODEL);
    foreach (stim_table[i]) send_item(stim_table[i]);
    drain();

    for (segment = 0; segment < 9; segment++) begin
      src_idle_pct = (segment < 3) ? 28 : (segment < 6) ? 55 : 0;
      dst_idle_pct = (segment < 3) ? 55 : (segment < 6) ? 28 : 0;
      case (segment)
        0: begin
          write_reg(REG_TENSOR_SIZE, TS_THREE);
          write_reg(REG_PLANE_STRESS, 2'd0);
          write_reg(REG_DIRECTION, 2'd0);
        end
        1: begin
          write_reg(REG_TENSOR_SIZE, 2'd3);
          write_reg(REG_PLANE_STRESS, 2'd1);
          write_reg(REG_DIRECTION, 2'd1);
        end
        2: begin
          write_reg(REG_TENSOR_SIZE, TS_FOUR);
          write_reg(REG_PLANE_STRESS, 2'd1);
          write_reg(REG_DIRECTION, 2'd0);
        end
        default: begin
          write_reg(REG_TENSOR_SIZE, 2'($urandom_range(0, 3)));
          write_reg(REG_PLANE_STRESS, 2'($urandom_range(0, 1)));
          write_reg(REG_DIRECTION, 2'($urandom_range(0, 1)));
        end
      endcase
      sent = 0;
      while (sent < 36) begin
        nload = $urandom_range(0, 12);
        for (int k = 0; k < nload; k++) begin
          send_item(random_row(4'($urandom_range(0, 15)), 1'b0));
          sent++;
        end
        // mostly a proper closing item, now and then a bare noise item
        send_item(random_row(4'($urandom_range(0, 15)), $urandom_range(0, 7) != 0));
        sent++;
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_stress.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
